// ===== hdl/lsfr_pkg.sv =====
// shared types and constants of the length/sync frame receiver
// depends on nothing; imported by the front end, back end and top level
`default_nettype none

package lsfr_pkg;

    localparam int DATA_W      = 8;
    localparam int TIMEOUT_W   = 16;
    localparam int QUEUE_DEPTH = 2;

    // item opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // special length values
    localparam logic [DATA_W-1:0] EMPTY_LEN      = 8'h00;
    localparam logic [DATA_W-1:0] ALL_ONES_LEN   = 8'hFF;
    localparam logic [DATA_W-1:0] SMALLEST_FRAME = 8'd3;

    // classified input item
    typedef struct packed {
        logic              tick;
        logic [DATA_W-1:0] data;
        logic              buf_free;
        logic              len_reserved;
        logic              len_short;
        logic              len_long;
    } t_item;

    // one result transaction
    typedef struct packed {
        logic              store_valid;
        logic [DATA_W-1:0] store_index;
        logic [DATA_W-1:0] store_data;
        logic              frame_good;
        logic              timed_out;
        logic              short_frame;
        logic              long_frame;
        logic              bad_length;
        logic              bad_sync;
        logic              bad_checksum;
        logic              byte_dropped;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/length_sync_frame_receiver.sv =====
// top level of the length/sync frame receiver: config registers and queues
// depends on lsfr_pkg, lsfr_queue, lsfr_front and lsfr_back
`default_nettype none

// Receives link bytes and timer ticks as queue transactions and returns at
// most one result transaction per item. A frame is a length byte L, its
// ones' complement as sync byte, L-3 payload bytes and two check bytes (an
// 8-bit running sum and sum of sums over length, sync and payload). Every
// frame byte comes back as a buffer store (length byte at index 0) together
// with event flags; a tick yields a result only when it times a frame out.
// Rate: one item per clock sustained while the result queue has room. A
// pushed item is registered in a short item queue, the back-end state
// machine updates all frame state as it takes the item, and its result
// is registered in a result queue whose head drives the result ports.
// When pop is held low the result queue fills and then the item queue,
// after which full rises. Registers at byte addresses 0 (min_length), 4
// (max_length), 8 (frame_timeout); write them only while no transaction
// is in flight.
module length_sync_frame_receiver #(
    parameter int QUEUE_DEPTH = lsfr_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // item side
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_opcode,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_buffer_free,

    // result side
    output logic             empty,
    input  wire logic        pop,
    output logic             o_store_valid,
    output logic [7:0]       o_store_index,
    output logic [7:0]       o_store_data,
    output logic             o_frame_good,
    output logic             o_timed_out,
    output logic             o_short_frame,
    output logic             o_long_frame,
    output logic             o_bad_length,
    output logic             o_bad_sync,
    output logic             o_bad_checksum,
    output logic             o_byte_dropped,

    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import lsfr_pkg::*;

    localparam logic [1:0] REG_MIN_LENGTH    = 2'd0;
    localparam logic [1:0] REG_MAX_LENGTH    = 2'd1;
    localparam logic [1:0] REG_FRAME_TIMEOUT = 2'd2;

    localparam int ITEM_W   = $bits(t_item);
    localparam int RESULT_W = $bits(t_result);

    // configuration registers
    logic [DATA_W-1:0]    r_min_length;
    logic [DATA_W-1:0]    r_max_length;
    logic [TIMEOUT_W-1:0] r_frame_timeout;
    logic                 cfg_write;
    logic [1:0]           reg_index;

    t_item             front_item;
    t_item             queued_item;
    logic [ITEM_W-1:0] queued_bits;
    logic              item_empty;
    logic              item_take;

    t_result             back_result;
    t_result             out_result;
    logic [RESULT_W-1:0] out_bits;
    logic                res_full;
    logic                res_push;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length    <= 8'd3;
            r_max_length    <= 8'd254;
            r_frame_timeout <= 16'd1000;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_MIN_LENGTH:    r_min_length    <= pwdata[DATA_W-1:0];
                REG_MAX_LENGTH:    r_max_length    <= pwdata[DATA_W-1:0];
                REG_FRAME_TIMEOUT: r_frame_timeout <= pwdata[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back; byte addresses 12 to 15 read as zero
    always_comb begin
        prdata = '0;
        unique case (reg_index)
            REG_MIN_LENGTH:    prdata = 32'(r_min_length);
            REG_MAX_LENGTH:    prdata = 32'(r_max_length);
            REG_FRAME_TIMEOUT: prdata = 32'(r_frame_timeout);
            default:           prdata = '0;
        endcase
    end

    // front end: classify each byte against the length limits on entry
    lsfr_front u_front (
        .i_opcode      (i_opcode),
        .i_rx_byte     (i_rx_byte),
        .i_buffer_free (i_buffer_free),
        .i_min_length  (r_min_length),
        .i_max_length  (r_max_length),
        .o_item        (front_item)
    );

    // item queue between front and back; full is the input backpressure
    lsfr_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_data  (front_item),
        .o_empty (item_empty),
        .i_pop   (item_take),
        .o_data  (queued_bits)
    );

    assign queued_item = t_item'(queued_bits);

    // back end: frame state, checksum and timeout
    lsfr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame_timeout (r_frame_timeout),
        .i_item          (queued_item),
        .i_item_valid    (!item_empty),
        .o_item_take     (item_take),
        .i_res_full      (res_full),
        .o_res_push      (res_push),
        .o_result        (back_result)
    );

    // result queue; its head drives the result ports
    lsfr_queue #(
        .WIDTH (RESULT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .o_full  (res_full),
        .i_data  (back_result),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (out_bits)
    );

    assign out_result     = t_result'(out_bits);
    assign o_store_valid  = out_result.store_valid;
    assign o_store_index  = out_result.store_index;
    assign o_store_data   = out_result.store_data;
    assign o_frame_good   = out_result.frame_good;
    assign o_timed_out    = out_result.timed_out;
    assign o_short_frame  = out_result.short_frame;
    assign o_long_frame   = out_result.long_frame;
    assign o_bad_length   = out_result.bad_length;
    assign o_bad_sync     = out_result.bad_sync;
    assign o_bad_checksum = out_result.bad_checksum;
    assign o_byte_dropped = out_result.byte_dropped;

endmodule

`default_nettype wire

// ===== hdl/lsfr_queue.sv =====
// small register queue with push/full and pop/empty sides
// no dependencies; used for the item queue and the result queue
`default_nettype none

module lsfr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lsfr_front.sv =====
// front end: decodes an incoming item and classifies the byte as a length
// depends on lsfr_pkg
`default_nettype none

module lsfr_front (
    input  wire logic                        i_opcode,
    input  wire logic [lsfr_pkg::DATA_W-1:0] i_rx_byte,
    input  wire logic                        i_buffer_free,
    input  wire logic [lsfr_pkg::DATA_W-1:0] i_min_length,
    input  wire logic [lsfr_pkg::DATA_W-1:0] i_max_length,
    output lsfr_pkg::t_item                  o_item
);

    import lsfr_pkg::*;

    logic [DATA_W-1:0] lo_limit;
    logic              reserved;
    logic              below;

    // a frame shorter than three bytes cannot hold sync and check bytes
    assign lo_limit = (i_min_length < SMALLEST_FRAME) ? SMALLEST_FRAME : i_min_length;
    assign reserved = (i_rx_byte == EMPTY_LEN) || (i_rx_byte == ALL_ONES_LEN);
    assign below    = !reserved && (i_rx_byte < lo_limit);

    always_comb begin
        o_item.tick         = (i_opcode == OP_TICK);
        o_item.data         = i_rx_byte;
        o_item.buf_free     = i_buffer_free;
        o_item.len_reserved = reserved;
        o_item.len_short    = below;
        o_item.len_long     = !reserved && !below && (i_rx_byte > i_max_length);
    end

endmodule

`default_nettype wire

// ===== hdl/lsfr_back.sv =====
// back end: frame state machine, checksum and timeout, one item per cycle while the result queue has room
// depends on lsfr_pkg
`default_nettype none

module lsfr_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [lsfr_pkg::TIMEOUT_W-1:0] i_frame_timeout,
    input  wire lsfr_pkg::t_item                i_item,
    input  wire logic                           i_item_valid,
    output logic                                o_item_take,
    input  wire logic                           i_res_full,
    output logic                                o_res_push,
    output lsfr_pkg::t_result                   o_result
);

    import lsfr_pkg::*;

    localparam logic [1:0] MODE_ACQUIRING = 2'd0;
    localparam logic [1:0] MODE_HUNTING   = 2'd1;
    localparam logic [1:0] MODE_SYNCING   = 2'd2;
    localparam logic [1:0] MODE_RECEIVING = 2'd3;

    localparam logic [TIMEOUT_W-1:0] GAP_MAX = '1;

    logic [1:0]           r_mode,      n_mode;
    logic [DATA_W-1:0]    r_bytes_left, n_bytes_left;
    logic [DATA_W-1:0]    r_write_pos, n_write_pos;
    logic [DATA_W-1:0]    r_sum,       n_sum;
    logic [DATA_W-1:0]    r_sum2,      n_sum2;
    logic [DATA_W-1:0]    r_check1,    n_check1;
    logic [TIMEOUT_W-1:0] r_gap,       n_gap;

    logic                 has_result;
    logic [TIMEOUT_W-1:0] gap_inc;
    logic                 len_ok;
    logic [DATA_W-1:0]    b;
    logic [DATA_W-1:0]    sync_sum;

    assign o_item_take = i_item_valid && !i_res_full;
    assign o_res_push  = o_item_take && has_result;

    assign b        = i_item.data;
    assign len_ok   = !i_item.len_reserved && !i_item.len_short && !i_item.len_long;
    assign gap_inc  = (r_gap == GAP_MAX) ? r_gap : TIMEOUT_W'(r_gap + 1'b1);
    assign sync_sum = DATA_W'(r_bytes_left + b);

    always_comb begin
        n_mode       = r_mode;
        n_bytes_left = r_bytes_left;
        n_write_pos  = r_write_pos;
        n_sum        = r_sum;
        n_sum2       = r_sum2;
        n_check1     = r_check1;
        n_gap        = r_gap;
        has_result   = 1'b0;
        o_result     = '0;

        if (i_item.tick) begin
            if (r_mode == MODE_SYNCING || r_mode == MODE_RECEIVING) begin
                n_gap = gap_inc;
                if (gap_inc >= i_frame_timeout) begin
                    n_mode             = MODE_HUNTING;
                    n_bytes_left       = '0;
                    n_gap              = '0;
                    has_result         = 1'b1;
                    o_result.timed_out = 1'b1;
                end
            end
        end else begin
            has_result = 1'b1;
            n_gap      = '0;
            unique case (r_mode)
                MODE_ACQUIRING, MODE_HUNTING: begin
                    if (r_mode == MODE_ACQUIRING && !i_item.buf_free) begin
                        o_result.byte_dropped = 1'b1;
                    end else begin
                        n_mode               = MODE_HUNTING;
                        o_result.short_frame = i_item.len_short;
                        o_result.long_frame  = i_item.len_long;
                        if (len_ok) begin
                            n_bytes_left         = b;
                            n_mode               = MODE_SYNCING;
                            o_result.store_valid = 1'b1;
                            o_result.store_data  = b;
                        end else begin
                            o_result.bad_length = 1'b1;
                        end
                    end
                end
                MODE_SYNCING: begin
                    if (b == ~r_bytes_left) begin
                        o_result.store_valid = 1'b1;
                        o_result.store_index = 8'd1;
                        o_result.store_data  = b;
                        n_sum        = sync_sum;
                        n_sum2       = DATA_W'(r_bytes_left + sync_sum);
                        n_bytes_left = DATA_W'(r_bytes_left - 1'b1);
                        n_write_pos  = 8'd2;
                        n_mode       = MODE_RECEIVING;
                    end else begin
                        // retry the failed sync byte as a fresh length
                        o_result.bad_sync    = 1'b1;
                        o_result.short_frame = i_item.len_short;
                        o_result.long_frame  = i_item.len_long;
                        if (len_ok) begin
                            n_bytes_left         = b;
                            o_result.store_valid = 1'b1;
                            o_result.store_data  = b;
                        end else begin
                            n_mode = MODE_HUNTING;
                        end
                    end
                end
                MODE_RECEIVING: begin
                    o_result.store_valid = 1'b1;
                    o_result.store_index = r_write_pos;
                    o_result.store_data  = b;
                    n_write_pos = DATA_W'(r_write_pos + 1'b1);
                    if (r_bytes_left > 8'd2) begin
                        n_sum        = DATA_W'(r_sum + b);
                        n_sum2       = DATA_W'(r_sum2 + n_sum);
                        n_bytes_left = DATA_W'(r_bytes_left - 1'b1);
                    end else if (r_bytes_left == 8'd2) begin
                        n_check1     = b;
                        n_bytes_left = 8'd1;
                    end else begin
                        n_bytes_left = '0;
                        if (r_sum == r_check1 && r_sum2 == b) begin
                            o_result.frame_good = 1'b1;
                            n_mode              = MODE_ACQUIRING;
                        end else begin
                            o_result.bad_checksum = 1'b1;
                            n_mode                = MODE_HUNTING;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_ACQUIRING;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_ACQUIRING;
            r_bytes_left <= '0;
            r_write_pos  <= '0;
            r_sum        <= '0;
            r_sum2       <= '0;
            r_check1     <= '0;
            r_gap        <= '0;
        end else if (o_item_take) begin
            r_mode       <= n_mode;
            r_bytes_left <= n_bytes_left;
            r_write_pos  <= n_write_pos;
            r_sum        <= n_sum;
            r_sum2       <= n_sum2;
            r_check1     <= n_check1;
            r_gap        <= n_gap;
        end
    end

endmodule

`default_nettype wire
